// ===== rtl/core/prc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and elaboration-time CORDIC tables for the point rotator.
package prc_pkg;

    localparam int COORD_W    = 32;
    localparam int ANGLE_W    = 26;
    localparam int ROUND_W    = 16;
    localparam int OFS_W      = COORD_W + 1;
    localparam int TRIG_W     = 34;
    localparam int TRIG_FRAC  = 30;
    localparam int Z_W        = 48;
    localparam int MAX_STAGES = 32;

    localparam int DEF_CORDIC_STAGES   = 24;
    localparam int DEF_COORD_FRAC_BITS = 16;

    // angle path widths
    localparam int RED_W   = ANGLE_W + 1;
    localparam int UMOD_W  = 25;
    localparam int AMAG_W  = 23;
    localparam int RAD_W   = 39;
    localparam int APROD_W = AMAG_W + RAD_W;

    // degrees in Q16.16
    localparam logic signed [RED_W-1:0] DEG_FULL    = 27'sd23592960;
    localparam logic signed [RED_W-1:0] DEG_HALF    = 27'sd11796480;
    localparam logic signed [RED_W-1:0] DEG_QUARTER = 27'sd5898240;

    localparam logic signed [ROUND_W-1:0] ROUND_HI = 16'sh7FFF;
    localparam logic signed [ROUND_W-1:0] ROUND_LO = 16'sh8000;

    typedef struct packed {
        logic signed [OFS_W-1:0]   dx;
        logic signed [OFS_W-1:0]   dy;
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
    } coord_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] x;
        logic signed [TRIG_W-1:0] y;
        logic signed [Z_W-1:0]    z;
        logic                     neg;
        coord_t                   coord;
    } cordic_t;

    // shift-subtract division, used only while elaborating constants
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(1/n) in Q60 by the alternating series, truncating each term
    function automatic logic [63:0] atan_inv_q60(input logic [63:0] n);
        logic [63:0] pw;
        logic [63:0] sum;
        logic [63:0] nn;
        logic [63:0] t;
        pw  = udiv64(64'd1 << 60, n);
        sum = '0;
        nn  = n * n;
        for (int k = 0; k < 64; k++) begin
            if (pw != '0) begin
                t = udiv64(pw, 64'(2 * k + 1));
                if (k[0]) begin
                    sum = sum - t;
                end else begin
                    sum = sum + t;
                end
                pw = udiv64(pw, nn);
            end
        end
        return sum;
    endfunction

    localparam logic [63:0] QUARTER_PI_Q60 = atan_inv_q60(64'd2) + atan_inv_q60(64'd3);

    localparam logic [RAD_W-1:0] RAD_PER_DEG_Q44 =
        RAD_W'(((64'd4 * QUARTER_PI_Q60) / 64'd180 + (64'd1 << 15)) >> 16);

    // atan(2^-idx) rounded to Q44
    function automatic logic [63:0] atan_q44(input int idx);
        logic [63:0] v;
        if (idx == 0) begin
            v = QUARTER_PI_Q60;
        end else begin
            v = atan_inv_q60(64'd1 << idx);
        end
        return (v + (64'd1 << 15)) >> 16;
    endfunction

    // 1/K in Q30 for a given number of iterations
    function automatic logic [63:0] kinv_q30(input int stages);
        logic [63:0] k2;
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        k2 = 64'd1 << 60;
        for (int i = 0; i < MAX_STAGES; i++) begin
            if (i < stages) begin
                k2 = k2 + (k2 >> (2 * i));
            end
        end
        x = k2;
        r = '0;
        b = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (b > x) begin
                b = b >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (b != '0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return udiv64((64'd1 << 60) + (r >> 1), r);
    endfunction

    // whole units, halves away from zero, saturated to 16 bits
    function automatic logic signed [ROUND_W-1:0] round_units(
        input logic signed [COORD_W-1:0] v,
        input int                        frac
    );
        logic signed [COORD_W:0] ext;
        logic [COORD_W:0]        mag;
        logic [COORD_W:0]        r;
        logic [COORD_W:0]        rn;
        logic signed [ROUND_W-1:0] res;
        ext = {v[COORD_W-1], v};
        mag = (ext < 0) ? -ext : ext;
        r   = (mag + ((COORD_W + 1)'(1) << (frac - 1))) >> frac;
        rn  = -r;
        if (v[COORD_W-1]) begin
            res = (r > (COORD_W + 1)'(32768)) ? ROUND_LO : rn[ROUND_W-1:0];
        end else begin
            res = (r > (COORD_W + 1)'(32767)) ? ROUND_HI : r[ROUND_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/prc_angle.sv =====
`timescale 1ns / 1ps
// Angle reduction, degree-to-radian scaling and offset formation ahead of the CORDIC.
module prc_angle
    import prc_pkg::*;
#(
    parameter int NUM_STAGES = DEF_CORDIC_STAGES
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_point_x,
    input  logic signed [COORD_W-1:0] s_point_y,
    input  logic signed [COORD_W-1:0] s_origin_x,
    input  logic signed [COORD_W-1:0] s_origin_y,
    input  logic signed [ANGLE_W-1:0] s_angle_deg,
    output logic                      out_valid,
    input  logic                      out_ready,
    output cordic_t                   out_data
);

    localparam logic [TRIG_W-1:0] KINV = TRIG_W'(kinv_q30(NUM_STAGES));

    // stage 1: angle modulo a full turn, offsets
    logic               v1_reg;
    logic [UMOD_W-1:0]  u_reg;
    coord_t             c1_reg;
    // stage 2: fold into the right half plane
    logic               v2_reg;
    logic [AMAG_W-1:0]  amag_reg;
    logic               sgn2_reg;
    logic               neg2_reg;
    coord_t             c2_reg;
    // stage 3: scale to radians
    logic               v3_reg;
    logic [APROD_W-1:0] prod_reg;
    logic               sgn3_reg;
    logic               neg3_reg;
    coord_t             c3_reg;
    // stage 4: rounded angle and CORDIC seed
    logic               v4_reg;
    cordic_t            out_reg;

    logic r1, r2, r3, r4;

    logic signed [RED_W-1:0] a_neg;
    logic signed [RED_W-1:0] u_wide;
    logic [UMOD_W-1:0]       u_next;
    coord_t                  c1_next;

    logic signed [RED_W-1:0] us;
    logic signed [RED_W-1:0] amag_wide;
    logic [AMAG_W-1:0]       amag_next;
    logic                    sgn_next;
    logic                    neg_next;

    logic [APROD_W-1:0] prod_next;
    logic [APROD_W-1:0] zmag;
    logic [Z_W-1:0]     zmag_cut;
    cordic_t            out_next;

    assign r4      = !v4_reg || out_ready;
    assign r3      = !v3_reg || r4;
    assign r2      = !v2_reg || r3;
    assign r1      = !v1_reg || r2;
    assign s_ready = r1;

    assign out_valid = v4_reg;
    assign out_data  = out_reg;

    // rotation is by the negated angle
    assign a_neg = -(RED_W'(s_angle_deg));

    always_comb begin
        if (a_neg < -DEG_FULL) begin
            u_wide = a_neg + DEG_FULL + DEG_FULL;
        end else if (a_neg < 0) begin
            u_wide = a_neg + DEG_FULL;
        end else if (a_neg >= DEG_FULL) begin
            u_wide = a_neg - DEG_FULL;
        end else begin
            u_wide = a_neg;
        end
    end

    assign u_next     = u_wide[UMOD_W-1:0];
    assign c1_next.dx = OFS_W'(s_point_x) - OFS_W'(s_origin_x);
    assign c1_next.dy = OFS_W'(s_point_y) - OFS_W'(s_origin_y);
    assign c1_next.ox = s_origin_x;
    assign c1_next.oy = s_origin_y;

    // fold: beyond a quarter turn either way, step half a turn and negate the result
    assign us = $signed({2'b00, u_reg});

    always_comb begin
        if (us <= DEG_QUARTER) begin
            amag_wide = us;
            sgn_next  = 1'b0;
            neg_next  = 1'b0;
        end else if (us < DEG_FULL - DEG_QUARTER) begin
            neg_next = 1'b1;
            if (us < DEG_HALF) begin
                amag_wide = DEG_HALF - us;
                sgn_next  = 1'b1;
            end else begin
                amag_wide = us - DEG_HALF;
                sgn_next  = 1'b0;
            end
        end else begin
            amag_wide = DEG_FULL - us;
            sgn_next  = 1'b1;
            neg_next  = 1'b0;
        end
    end

    assign amag_next = amag_wide[AMAG_W-1:0];

    assign prod_next = APROD_W'(amag_reg) * APROD_W'(RAD_PER_DEG_Q44);

    assign zmag     = (prod_reg + (APROD_W'(1) << 15)) >> 16;
    assign zmag_cut = zmag[Z_W-1:0];

    always_comb begin
        out_next.x     = $signed(KINV);
        out_next.y     = '0;
        out_next.z     = sgn3_reg ? $signed(-zmag_cut) : $signed(zmag_cut);
        out_next.neg   = neg3_reg;
        out_next.coord = c3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (r1) begin
                v1_reg <= s_valid;
            end
            if (r2) begin
                v2_reg <= v1_reg;
            end
            if (r3) begin
                v3_reg <= v2_reg;
            end
            if (r4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (r1 && s_valid) begin
            u_reg  <= u_next;
            c1_reg <= c1_next;
        end
        if (r2 && v1_reg) begin
            amag_reg <= amag_next;
            sgn2_reg <= sgn_next;
            neg2_reg <= neg_next;
            c2_reg   <= c1_reg;
        end
        if (r3 && v2_reg) begin
            prod_reg <= prod_next;
            sgn3_reg <= sgn2_reg;
            neg3_reg <= neg2_reg;
            c3_reg   <= c2_reg;
        end
        if (r4 && v3_reg) begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== rtl/core/prc_cordic_stage.sv =====
`timescale 1ns / 1ps
// One registered CORDIC rotation iteration with a fixed shift and arctangent.
module prc_cordic_stage
    import prc_pkg::*;
#(
    parameter int STAGE_IDX = 0
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  cordic_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output cordic_t out_data
);

    localparam logic [Z_W-1:0] ATAN = Z_W'(atan_q44(STAGE_IDX));

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;

    logic signed [TRIG_W-1:0] xs;
    logic signed [TRIG_W-1:0] ys;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign xs = in_data.x >>> STAGE_IDX;
    assign ys = in_data.y >>> STAGE_IDX;

    always_comb begin
        data_next = in_data;
        if (in_data.z >= 0) begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - $signed(ATAN);
        end else begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + $signed(ATAN);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/core/prc_combine.sv =====
`timescale 1ns / 1ps
// Quadrant sign fix, offset products, recentring, saturation and unit rounding.
module prc_combine
    import prc_pkg::*;
#(
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  cordic_t                   in_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COORD_W-1:0] m_rot_x,
    output logic signed [COORD_W-1:0] m_rot_y,
    output logic signed [ROUND_W-1:0] m_round_x,
    output logic signed [ROUND_W-1:0] m_round_y
);

    localparam int PROD_W = OFS_W + TRIG_W;
    localparam int TERM_W = PROD_W - TRIG_FRAC;
    localparam int SUM_W  = TERM_W + 1;

    localparam logic signed [PROD_W-1:0] RND = PROD_W'(1) << (TRIG_FRAC - 1);
    localparam logic signed [SUM_W-1:0]  SAT_HI = SUM_W'(32'sh7FFFFFFF);
    localparam logic signed [SUM_W-1:0]  SAT_LO = SUM_W'(32'sh80000000);

    function automatic logic signed [TERM_W-1:0] round_term(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] q;
        q = (p + RND) >>> TRIG_FRAC;
        return q[TERM_W-1:0];
    endfunction

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end else begin
            c = v;
        end
        return c[COORD_W-1:0];
    endfunction

    // stage n: signed cos and sin
    logic                     vn_reg;
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    coord_t                   cn_reg;
    // stage m: products
    logic                     vm_reg;
    logic signed [PROD_W-1:0] p_xc_reg;
    logic signed [PROD_W-1:0] p_ys_reg;
    logic signed [PROD_W-1:0] p_xs_reg;
    logic signed [PROD_W-1:0] p_yc_reg;
    logic signed [COORD_W-1:0] oxm_reg;
    logic signed [COORD_W-1:0] oym_reg;
    // stage r: rounded terms
    logic                     vr_reg;
    logic signed [TERM_W-1:0] t_xc_reg;
    logic signed [TERM_W-1:0] t_ys_reg;
    logic signed [TERM_W-1:0] t_xs_reg;
    logic signed [TERM_W-1:0] t_yc_reg;
    logic signed [COORD_W-1:0] oxr_reg;
    logic signed [COORD_W-1:0] oyr_reg;
    // stage s: saturated point
    logic                      vs_reg;
    logic signed [COORD_W-1:0] rxs_reg;
    logic signed [COORD_W-1:0] rys_reg;
    // stage o: output register
    logic                      vo_reg;
    logic signed [COORD_W-1:0] rot_x_reg;
    logic signed [COORD_W-1:0] rot_y_reg;
    logic signed [ROUND_W-1:0] round_x_reg;
    logic signed [ROUND_W-1:0] round_y_reg;

    logic rn, rm, rr, rs, ro;

    logic signed [SUM_W-1:0] rx_next;
    logic signed [SUM_W-1:0] ry_next;

    assign ro       = !vo_reg || m_ready;
    assign rs       = !vs_reg || ro;
    assign rr       = !vr_reg || rs;
    assign rm       = !vm_reg || rr;
    assign rn       = !vn_reg || rm;
    assign in_ready = rn;

    assign m_valid   = vo_reg;
    assign m_rot_x   = rot_x_reg;
    assign m_rot_y   = rot_y_reg;
    assign m_round_x = round_x_reg;
    assign m_round_y = round_y_reg;

    assign rx_next = SUM_W'(t_xc_reg) - SUM_W'(t_ys_reg) + SUM_W'(oxr_reg);
    assign ry_next = SUM_W'(t_xs_reg) + SUM_W'(t_yc_reg) + SUM_W'(oyr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vn_reg <= 1'b0;
            vm_reg <= 1'b0;
            vr_reg <= 1'b0;
            vs_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rn) begin
                vn_reg <= in_valid;
            end
            if (rm) begin
                vm_reg <= vn_reg;
            end
            if (rr) begin
                vr_reg <= vm_reg;
            end
            if (rs) begin
                vs_reg <= vr_reg;
            end
            if (ro) begin
                vo_reg <= vs_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rn && in_valid) begin
            cos_reg <= in_data.neg ? -in_data.x : in_data.x;
            sin_reg <= in_data.neg ? -in_data.y : in_data.y;
            cn_reg  <= in_data.coord;
        end
        if (rm && vn_reg) begin
            p_xc_reg <= PROD_W'(cn_reg.dx) * PROD_W'(cos_reg);
            p_ys_reg <= PROD_W'(cn_reg.dy) * PROD_W'(sin_reg);
            p_xs_reg <= PROD_W'(cn_reg.dx) * PROD_W'(sin_reg);
            p_yc_reg <= PROD_W'(cn_reg.dy) * PROD_W'(cos_reg);
            oxm_reg  <= cn_reg.ox;
            oym_reg  <= cn_reg.oy;
        end
        if (rr && vm_reg) begin
            t_xc_reg <= round_term(p_xc_reg);
            t_ys_reg <= round_term(p_ys_reg);
            t_xs_reg <= round_term(p_xs_reg);
            t_yc_reg <= round_term(p_yc_reg);
            oxr_reg  <= oxm_reg;
            oyr_reg  <= oym_reg;
        end
        if (rs && vr_reg) begin
            rxs_reg <= sat32(rx_next);
            rys_reg <= sat32(ry_next);
        end
        if (ro && vs_reg) begin
            rot_x_reg   <= rxs_reg;
            rot_y_reg   <= rys_reg;
            round_x_reg <= round_units(rxs_reg, COORD_FRAC_BITS);
            round_y_reg <= round_units(rys_reg, COORD_FRAC_BITS);
        end
    end

endmodule

// ===== rtl/core/point_rotate_about_origin.sv =====
`timescale 1ns / 1ps
// Top level: CORDIC point rotation about an origin, fully pipelined.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | point_x, point_y, origin_x, origin_y, angle_deg
//  m_      | out       | m_valid / m_ready  | rot_x, rot_y, round_x, round_y
//
// One request enters per cycle while the output is not stalled; the pipeline has four
// angle stages, one stage per CORDIC iteration (capped at MAX_STAGES) and five output stages.
// Reset is synchronous and active low and clears only the valid bits.
// A stalled output holds its stage; each stage refills while it holds a bubble,
// so requests keep entering until every stage is occupied.
module point_rotate_about_origin
    import prc_pkg::*;
#(
    parameter int CORDIC_STAGES   = DEF_CORDIC_STAGES,
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_point_x,
    input  logic signed [COORD_W-1:0] s_point_y,
    input  logic signed [COORD_W-1:0] s_origin_x,
    input  logic signed [COORD_W-1:0] s_origin_y,
    input  logic signed [ANGLE_W-1:0] s_angle_deg,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COORD_W-1:0] m_rot_x,
    output logic signed [COORD_W-1:0] m_rot_y,
    output logic signed [ROUND_W-1:0] m_round_x,
    output logic signed [ROUND_W-1:0] m_round_y
);

    localparam int NUM_STAGES = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

    logic [NUM_STAGES:0] stage_valid;
    logic [NUM_STAGES:0] stage_ready;
    cordic_t             stage_data [NUM_STAGES+1];

    prc_angle #(
        .NUM_STAGES (NUM_STAGES)
    ) u_angle (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_point_x   (s_point_x),
        .s_point_y   (s_point_y),
        .s_origin_x  (s_origin_x),
        .s_origin_y  (s_origin_y),
        .s_angle_deg (s_angle_deg),
        .out_valid   (stage_valid[0]),
        .out_ready   (stage_ready[0]),
        .out_data    (stage_data[0])
    );

    for (genvar i = 0; i < NUM_STAGES; i++) begin : g_cordic
        prc_cordic_stage #(
            .STAGE_IDX (i)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_ready (stage_ready[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    prc_combine #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_combine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (stage_valid[NUM_STAGES]),
        .in_ready  (stage_ready[NUM_STAGES]),
        .in_data   (stage_data[NUM_STAGES]),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_rot_x   (m_rot_x),
        .m_rot_y   (m_rot_y),
        .m_round_x (m_round_x),
        .m_round_y (m_round_y)
    );

endmodule

// ===== rtl/core/prc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the point rotator, with its bind to the top level.
module prc_checker
    import prc_pkg::*;
#(
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic signed [COORD_W-1:0] m_rot_x,
    input logic signed [COORD_W-1:0] m_rot_y,
    input logic signed [ROUND_W-1:0] m_round_x,
    input logic signed [ROUND_W-1:0] m_round_y
);

    // requests accepted and not yet delivered
    logic [7:0] pending_reg;
    logic [7:0] pending_next;

    assign pending_next = pending_reg + 8'(s_valid && s_ready) - 8'(m_valid && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rot_x) && $stable(m_rot_y)
            && $stable(m_round_x) && $stable(m_round_y))
        else $error("result changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_round_x: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_round_x == round_units(m_rot_x, COORD_FRAC_BITS))
        else $error("round_x disagrees with rot_x");

    a_round_y: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_round_y == round_units(m_rot_y, COORD_FRAC_BITS))
        else $error("round_y disagrees with rot_y");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != '0)
        else $error("result offered with no request in flight");

endmodule

bind point_rotate_about_origin prc_checker #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
) u_prc_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the CORDIC point rotator: stimulus, rotation predictor and checker.
module tb;
    import prc_pkg::*;

    localparam int    FRAC_BITS   = DEF_COORD_FRAC_BITS;
    localparam int    USED_STAGES = (DEF_CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES
                                                                     : DEF_CORDIC_STAGES;
    localparam int    LATENCY     = DEF_CORDIC_STAGES + 9;
    localparam int    CYCLE_LIMIT = 250000;
    localparam int    ONE         = 1 << FRAC_BITS;
    localparam longint TURN_Q16   = longint'(DEG_FULL);
    localparam longint HALF_Q16   = longint'(DEG_HALF);
    localparam longint QUART_Q16  = longint'(DEG_QUARTER);
    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ANGLE_W-1:0] A_FULL  = ANGLE_W'(DEG_FULL);
    localparam logic signed [ANGLE_W-1:0] A_HALF  = ANGLE_W'(DEG_HALF);
    localparam logic signed [ANGLE_W-1:0] A_QUART = ANGLE_W'(DEG_QUARTER);

    typedef struct {
        logic signed [COORD_W-1:0] rot_x;
        logic signed [COORD_W-1:0] rot_y;
        logic signed [ROUND_W-1:0] round_x;
        logic signed [ROUND_W-1:0] round_y;
    } rot_result_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [COORD_W-1:0] s_point_x;
    logic signed [COORD_W-1:0] s_point_y;
    logic signed [COORD_W-1:0] s_origin_x;
    logic signed [COORD_W-1:0] s_origin_y;
    logic signed [ANGLE_W-1:0] s_angle_deg;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [COORD_W-1:0] m_rot_x;
    logic signed [COORD_W-1:0] m_rot_y;
    logic signed [ROUND_W-1:0] m_round_x;
    logic signed [ROUND_W-1:0] m_round_y;

    longint          atan_tab [MAX_STAGES];
    longint unsigned rad_per_deg;
    longint unsigned gain_inv;

    rot_result_t pending_rot [$];
    int          mismatch_count = 0;
    int          requests_sent  = 0;
    int          results_seen   = 0;
    int          cycle_count    = 0;
    bit          throttle       = 1'b0;

    point_rotate_about_origin #(
        .CORDIC_STAGES  (DEF_CORDIC_STAGES),
        .COORD_FRAC_BITS(DEF_COORD_FRAC_BITS)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_point_x  (s_point_x),
        .s_point_y  (s_point_y),
        .s_origin_x (s_origin_x),
        .s_origin_y (s_origin_y),
        .s_angle_deg(s_angle_deg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_rot_x    (m_rot_x),
        .m_rot_y    (m_rot_y),
        .m_round_x  (m_round_x),
        .m_round_y  (m_round_y)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // atan(1/n) at scale 2^60, alternating series with truncated terms
    function automatic longint unsigned arctan_recip_q60(input longint unsigned n);
        longint unsigned pw;
        longint unsigned acc;
        longint unsigned nn;
        longint unsigned term;
        pw  = (64'd1 << 60) / n;
        acc = 0;
        nn  = n * n;
        for (int k = 0; k < 64 && pw != 0; k++) begin
            term = pw / longint'(2 * k + 1);
            if (k % 2) begin
                acc -= term;
            end else begin
                acc += term;
            end
            pw /= nn;
        end
        return acc;
    endfunction

    // arctangent table, degree scale and inverse gain, built once at time zero
    initial begin
        longint unsigned quarter_pi;
        longint unsigned k2;
        longint unsigned root;
        longint unsigned trial;
        quarter_pi  = arctan_recip_q60(2) + arctan_recip_q60(3);
        atan_tab[0] = longint'((quarter_pi + 64'd32768) >> 16);
        for (int i = 1; i < MAX_STAGES; i++) begin
            atan_tab[i] = longint'((arctan_recip_q60(64'd1 << i) + 64'd32768) >> 16);
        end
        rad_per_deg = ((64'd4 * quarter_pi) / 64'd180 + 64'd32768) >> 16;
        k2 = 64'd1 << 60;
        for (int i = 0; i < USED_STAGES; i++) begin
            k2 += k2 >> (2 * i);
        end
        // floor square root, one bit at a time; the root stays below 2^31
        root = 0;
        for (int b = 30; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= k2) begin
                root = trial;
            end
        end
        gain_inv = ((64'd1 << 60) + root / 2) / root;
    end

    function automatic longint saturate(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint fix_mul(input longint a, input longint b);
        return (a * b + (longint'(1) << (TRIG_FRAC - 1))) >>> TRIG_FRAC;
    endfunction

    function automatic logic signed [ROUND_W-1:0] to_units(input longint v);
        longint mag;
        longint r;
        mag = (v < 0) ? -v : v;
        r   = (mag + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (v < 0) begin
            r = -r;
        end
        return ROUND_W'(saturate(r, -32768, 32767));
    endfunction

    function automatic rot_result_t rotate_point(
        input logic signed [COORD_W-1:0] px, py, ox, oy,
        input logic signed [ANGLE_W-1:0] ang
    );
        rot_result_t     res;
        longint          a;
        longint          z;
        longint          cx;
        longint          sy;
        longint          xs;
        longint          ys;
        longint          dx;
        longint          dy;
        longint          rx;
        longint          ry;
        longint unsigned amag;
        bit              flip;
        // clockwise: negate, then fold into (-180, 180] and onto +-90
        a = -longint'(ang);
        a = a % TURN_Q16;
        if (a < 0) begin
            a += TURN_Q16;
        end
        if (a > HALF_Q16) begin
            a -= TURN_Q16;
        end
        flip = 1'b0;
        if (a > QUART_Q16) begin
            a -= HALF_Q16;
            flip = 1'b1;
        end else if (a < -QUART_Q16) begin
            a += HALF_Q16;
            flip = 1'b1;
        end
        amag = (a < 0) ? -a : a;
        z = longint'((amag * rad_per_deg + 64'd32768) >> 16);
        if (a < 0) begin
            z = -z;
        end
        cx = longint'(gain_inv);
        sy = 0;
        for (int i = 0; i < USED_STAGES; i++) begin
            xs = cx >>> i;
            ys = sy >>> i;
            if (z >= 0) begin
                cx -= ys;
                sy += xs;
                z  -= atan_tab[i];
            end else begin
                cx += ys;
                sy -= xs;
                z  += atan_tab[i];
            end
        end
        if (flip) begin
            cx = -cx;
            sy = -sy;
        end
        dx = longint'(px) - longint'(ox);
        dy = longint'(py) - longint'(oy);
        rx = fix_mul(dx, cx) - fix_mul(dy, sy) + longint'(ox);
        ry = fix_mul(dx, sy) + fix_mul(dy, cx) + longint'(oy);
        rx = saturate(rx, longint'(C_MIN), longint'(C_MAX));
        ry = saturate(ry, longint'(C_MIN), longint'(C_MAX));
        res.rot_x   = COORD_W'(rx);
        res.rot_y   = COORD_W'(ry);
        res.round_x = to_units(rx);
        res.round_y = to_units(ry);
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 0;
        end
        if (pick < 85) begin
            return $urandom_range(1, 3);
        end
        if (pick < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [COORD_W-1:0] edge_coord();
        case ($urandom_range(0, 3))
            0: return C_MIN;
            1: return C_MAX;
            2: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] sprite_coord();
        return int'($urandom_range(0, 4000 * ONE)) - 2000 * ONE;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] any_angle();
        return ANGLE_W'(int'($urandom_range(0, 2 * 23592960)) - 23592960);
    endfunction

    // hold the request until accepted, then queue its predicted rotation
    task automatic send_point(
        input logic signed [COORD_W-1:0] px, py, ox, oy,
        input logic signed [ANGLE_W-1:0] ang
    );
        int gap;
        gap = throttle ? idle_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_point_x   <= px;
        s_point_y   <= py;
        s_origin_x  <= ox;
        s_origin_y  <= oy;
        s_angle_deg <= ang;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_rot.push_back(rotate_point(px, py, ox, oy, ang));
        requests_sent++;
    endtask

    task automatic test_corner_cases();
        throttle = 1'b0;
        send_point(10 * ONE, 0, 0, 0, 0);
        send_point(10 * ONE, 0, 0, 0, A_QUART);
        send_point(10 * ONE, 3 * ONE, 0, 0, -A_QUART);
        send_point(-7 * ONE, 5 * ONE, ONE, -ONE, A_HALF);
        send_point(-7 * ONE, 5 * ONE, ONE, -ONE, -A_HALF);
        send_point(4 * ONE, 9 * ONE, 0, 0, A_HALF + A_QUART);
        send_point(12345678, -8765432, 1000, -2000, A_FULL);
        send_point(12345678, -8765432, 1000, -2000, -A_FULL);
        send_point(5 * ONE, 7 * ONE, 3 * ONE, 4 * ONE, A_QUART / 2);
        // just either side of the quarter and half turn folds
        send_point(ONE, ONE, 0, 0, A_QUART + 1);
        send_point(ONE, ONE, 0, 0, -A_QUART - 1);
        send_point(ONE, -ONE, 0, 0, A_HALF - 1);
        send_point(ONE, -ONE, 0, 0, -A_HALF + 1);
        send_point(3 * ONE, 2 * ONE, 0, 0, 1);
        send_point(3 * ONE, 2 * ONE, 0, 0, -1);
        // offsets wider than 32 bits, saturation at both ends
        send_point(C_MAX, C_MAX, C_MIN, C_MIN, 0);
        send_point(C_MAX, C_MAX, C_MIN, C_MIN, A_HALF);
        send_point(C_MIN, C_MIN, C_MAX, C_MAX, A_HALF);
        send_point(C_MIN, C_MAX, 0, 0, A_QUART / 2);
        send_point(C_MAX, C_MAX, C_MAX, C_MAX, ANGLE_W'(37 * ONE));
        // halves, and rounding beyond the 16-bit range
        send_point(5 * ONE / 2, -5 * ONE / 2, 0, 0, 0);
        send_point(32'sh7FFF_C000, 32'sh8000_4000, 0, 0, 0);
        send_point(32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555, 11184810);
        send_point(32'shAAAA_AAAA, 32'sh5555_5555, 32'sh5555_5555, 32'shAAAA_AAAA, -11184810);
    endtask

    task automatic test_random_rotations(input int count);
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        int                        ang;
        for (int n = 0; n < count; n++) begin
            // drop the idling for a stretch in every seventy requests
            throttle = (n % 70) >= 15;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    send_point(sprite_coord(), sprite_coord(), sprite_coord(),
                               sprite_coord(), any_angle());
                end
                5, 6: begin
                    send_point($urandom, $urandom, $urandom, $urandom, any_angle());
                end
                7: begin
                    ang = (int'($urandom_range(0, 8)) - 4) * 5898240
                          + int'($urandom_range(0, 4)) - 2;
                    ang = (ang > 23592960) ? 23592960 : ((ang < -23592960) ? -23592960 : ang);
                    send_point(sprite_coord(), sprite_coord(), sprite_coord(),
                               sprite_coord(), ANGLE_W'(ang));
                end
                8: begin
                    ox = edge_coord();
                    oy = edge_coord();
                    if ($urandom_range(0, 3) == 0) begin
                        send_point(ox, oy, ox, oy, any_angle());
                    end else begin
                        send_point(edge_coord(), edge_coord(), ox, oy, any_angle());
                    end
                end
                default: begin
                    send_point((int'($urandom_range(0, 2000)) - 1000) * ONE + ONE / 2,
                               (int'($urandom_range(0, 2000)) - 1000) * ONE - ONE / 2,
                               (int'($urandom_range(0, 20)) - 10) * ONE,
                               (int'($urandom_range(0, 20)) - 10) * ONE,
                               ANGLE_W'((int'($urandom_range(0, 8)) - 4) * 5898240));
                end
            endcase
        end
    endtask

    task automatic test_full_rate_stream(input int count);
        throttle = 1'b0;
        for (int n = 0; n < count; n++) begin
            send_point(sprite_coord(), sprite_coord(), sprite_coord(), sprite_coord(),
                       any_angle());
        end
    endtask

    task automatic check_field(input string label, input longint want, input longint got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    always @(posedge aclk) begin
        rot_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_rot.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: unexpected result, expected none, actual rot_x %0d rot_y %0d",
                         $time, m_rot_x, m_rot_y);
            end else begin
                want = pending_rot.pop_front();
                check_field("rot_x", want.rot_x, m_rot_x);
                check_field("rot_y", want.rot_y, m_rot_y);
                check_field("round_x", want.round_x, m_round_x);
                check_field("round_y", want.round_y, m_round_y);
            end
        end
    end

    // result side: ready held high while unthrottled, else bursts of ready broken by stalls of random length
    initial begin
        int hold;
        m_ready <= 1'b0;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (!throttle) begin
                m_ready <= 1'b1;
                hold = 0;
            end else if (hold > 0) begin
                hold--;
            end else if (m_ready) begin
                m_ready <= 1'b0;
                hold = idle_len();
            end else begin
                m_ready <= 1'b1;
                hold = $urandom_range(0, 12);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t ns: timeout after %0d cycles, %0d results outstanding",
                 $time, cycle_count, pending_rot.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_point_x   <= '0;
        s_point_y   <= '0;
        s_origin_x  <= '0;
        s_origin_y  <= '0;
        s_angle_deg <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_corner_cases();
        test_random_rotations(350);
        test_full_rate_stream(60);
        s_valid <= 1'b0;
        while (pending_rot.size() != 0) @(posedge aclk);
        repeat (2 * LATENCY) @(posedge aclk);
        $display("Sent %0d rotation requests: corner angles and coordinates, random traffic",
                 requests_sent);
        $display("with gaps and stalls, and a full-rate burst; %0d results checked.",
                 results_seen);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
